### hw/rtl/mrsp_pkg.sv
package mrsp_pkg;

    localparam int unsigned KIND_W  = 4;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned KEY_W   = 7;
    localparam int unsigned VALUE_W = 15;
    localparam int unsigned LEN_W   = 6;

    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_SYS_RESET   = 8'hFF;

    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_KEY_PRESS = 4'hA;
    localparam logic [3:0] HI_CTRL      = 4'hB;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_CHAN_PRES = 4'hD;
    localparam logic [3:0] HI_BEND      = 4'hE;

    typedef enum logic [KIND_W-1:0] {
        EV_PROGRAM    = 4'd0,
        EV_CHAN_PRES  = 4'd1,
        EV_NOTE_OFF   = 4'd2,
        EV_NOTE_ON    = 4'd3,
        EV_KEY_PRESS  = 4'd4,
        EV_CTRL       = 4'd5,
        EV_BEND       = 4'd6,
        EV_RESET      = 4'd7,
        EV_SYSEX_BYTE = 4'd8,
        EV_SYSEX_END  = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_PARAM  = 2'd1,
        MODE_SYSEX  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SEND = 2'd1,
        BK_END  = 2'd2
    } t_bstate;

    typedef struct packed {
        t_kind               kind;
        logic [CHAN_W-1:0]   chan;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } t_evt;

    localparam int unsigned EVT_W = $bits(t_evt);

endpackage

### hw/rtl/mrsp_front.sv
module mrsp_front #(
    parameter int unsigned SYSEX_DEPTH = 64,
    parameter int unsigned AW          = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output mrsp_pkg::t_evt       o_q_evt,
    output logic                 o_q_is_end,
    output logic [AW-1:0]        o_q_len,
    output logic                 o_mem_we,
    output logic [AW-1:0]        o_mem_addr,
    output logic [7:0]           o_mem_data,
    input  logic                 i_sx_done
);
    import mrsp_pkg::*;

    logic          r_enable;
    t_mode         r_mode, n_mode;
    logic [7:0]    r_status, n_status;
    logic [6:0]    r_first, n_first;
    logic [AW-1:0] r_count, n_count;
    logic          r_sx_busy, n_sx_busy;
    logic          accept;
    logic [3:0]    hi;
    logic          below_top;

    assign hi        = r_status[7:4];
    assign below_top = (r_count != AW'(SYSEX_DEPTH - 1));

    // Sysex bytes wait while the back end still replays the store.
    assign o_in_stall = i_q_full || ((r_mode == MODE_SYSEX) && r_sx_busy);
    assign accept     = i_in_valid && !o_in_stall && r_enable;

    always_comb begin
        n_mode      = r_mode;
        n_status    = r_status;
        n_first     = r_first;
        n_count     = r_count;
        n_sx_busy   = r_sx_busy;
        o_q_push    = 1'b0;
        o_q_evt     = '0;
        o_q_is_end  = 1'b0;
        o_q_len     = r_count;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_count;
        o_mem_data  = i_in_byte;
        if (i_sx_done) begin
            n_sx_busy = 1'b0;
        end
        if (accept) begin
            unique case (r_mode)
                MODE_PARAM: begin
                    o_q_evt.chan  = r_status[3:0];
                    o_q_evt.key   = r_first;
                    o_q_evt.value = VALUE_W'(i_in_byte);
                    unique case (hi)
                        HI_NOTE_OFF: begin
                            o_q_push      = 1'b1;
                            o_q_evt.kind  = EV_NOTE_OFF;
                            o_q_evt.value = '0;
                        end
                        HI_NOTE_ON: begin
                            o_q_push     = 1'b1;
                            o_q_evt.kind = (i_in_byte == 8'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
                        end
                        HI_KEY_PRESS: begin
                            o_q_push     = 1'b1;
                            o_q_evt.kind = EV_KEY_PRESS;
                        end
                        HI_CTRL: begin
                            o_q_push     = 1'b1;
                            o_q_evt.kind = EV_CTRL;
                        end
                        HI_BEND: begin
                            o_q_push      = 1'b1;
                            o_q_evt.kind  = EV_BEND;
                            o_q_evt.value = {i_in_byte, r_first};
                        end
                        default: begin
                        end
                    endcase
                    n_mode = MODE_NORMAL;
                end
                MODE_SYSEX: begin
                    if (i_in_byte == BYTE_SYSEX_END) begin
                        if (below_top) begin
                            o_q_push     = 1'b1;
                            o_q_is_end   = 1'b1;
                            o_q_evt.kind = EV_SYSEX_END;
                            n_sx_busy    = 1'b1;
                        end
                        n_mode = MODE_NORMAL;
                    end else begin
                        o_mem_we = 1'b1;
                        if (below_top) begin
                            n_count = AW'(r_count + 1'b1);
                        end
                    end
                end
                default: begin
                    // Normal mode; the unused mode code behaves the same way.
                    o_q_evt.chan  = r_status[3:0];
                    o_q_evt.value = VALUE_W'(i_in_byte);
                    if (!i_in_byte[7]) begin
                        if (hi == HI_PROGRAM) begin
                            o_q_push     = 1'b1;
                            o_q_evt.kind = EV_PROGRAM;
                        end else if (hi == HI_CHAN_PRES) begin
                            o_q_push     = 1'b1;
                            o_q_evt.kind = EV_CHAN_PRES;
                        end else if (r_status[7]) begin
                            n_first = i_in_byte[6:0];
                            n_mode  = MODE_PARAM;
                        end
                    end else if (i_in_byte < BYTE_SYSEX_START) begin
                        n_status = i_in_byte;
                    end else if (i_in_byte == BYTE_SYSEX_START) begin
                        n_count = '0;
                        n_mode  = MODE_SYSEX;
                    end else if (i_in_byte == BYTE_SYS_RESET) begin
                        o_q_push      = 1'b1;
                        o_q_evt       = '0;
                        o_q_evt.kind  = EV_RESET;
                        n_status      = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_mode    <= MODE_NORMAL;
            r_status  <= '0;
            r_first   <= '0;
            r_count   <= '0;
            r_sx_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            r_mode    <= n_mode;
            r_status  <= n_status;
            r_first   <= n_first;
            r_count   <= n_count;
            r_sx_busy <= n_sx_busy;
        end
    end

endmodule

### hw/rtl/mrsp_queue.sv
module mrsp_queue #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    import mrsp_pkg::*;

    logic [W-1:0] r_slot [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_fill <= 2'(r_fill + {1'b0, i_push} - {1'b0, i_pop});
        end
    end

endmodule

### hw/rtl/mrsp_back.sv
module mrsp_back #(
    parameter int unsigned SYSEX_DEPTH = 64,
    parameter int unsigned AW          = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  mrsp_pkg::t_evt                i_q_evt,
    input  logic                          i_q_is_end,
    input  logic [AW-1:0]                 i_q_len,
    output logic                          o_q_pop,
    input  logic                          i_mem_we,
    input  logic [AW-1:0]                 i_mem_addr,
    input  logic [7:0]                    i_mem_data,
    output logic                          o_sx_done,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mrsp_pkg::t_evt                o_evt,
    output logic [AW-1:0]                 o_len,
    output logic                          o_last
);
    import mrsp_pkg::*;

    logic [7:0]    r_mem [SYSEX_DEPTH];
    logic [7:0]    r_rdata;
    t_bstate       r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_out_valid;
    t_evt          r_evt, n_evt;
    logic [AW-1:0] r_len, n_len;
    logic          r_last, n_last;
    logic          can_load, load;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_evt       = r_evt;
    assign o_len       = r_len;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            r_mem[i_mem_addr] <= i_mem_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_evt     = r_evt;
        n_len     = r_len;
        n_last    = r_last;
        load      = 1'b0;
        o_q_pop   = 1'b0;
        o_sx_done = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = AW'(r_idx + 1'b1);
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && can_load) begin
                    o_q_pop = 1'b1;
                    if (!i_q_is_end) begin
                        load   = 1'b1;
                        n_evt  = i_q_evt;
                        n_len  = '0;
                        n_last = 1'b1;
                    end else if (i_q_len == '0) begin
                        load      = 1'b1;
                        n_evt     = '0;
                        n_evt.kind = EV_SYSEX_END;
                        n_len     = '0;
                        n_last    = 1'b1;
                        o_sx_done = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_idx   = '0;
                        n_cnt   = i_q_len;
                        n_state = BK_SEND;
                    end
                end
            end
            BK_SEND: begin
                if (can_load) begin
                    load        = 1'b1;
                    n_evt       = '0;
                    n_evt.kind  = EV_SYSEX_BYTE;
                    n_evt.value = VALUE_W'(r_rdata);
                    n_len       = '0;
                    n_last      = 1'b0;
                    if (r_idx == AW'(r_cnt - 1'b1)) begin
                        n_state = BK_END;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = AW'(r_idx + 1'b1);
                    end
                end
            end
            BK_END: begin
                if (can_load) begin
                    load       = 1'b1;
                    n_evt      = '0;
                    n_evt.kind = EV_SYSEX_END;
                    n_len      = r_cnt;
                    n_last     = 1'b1;
                    o_sx_done  = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= load || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        if (load) begin
            r_evt  <= n_evt;
            r_len  <= n_len;
            r_last <= n_last;
        end
    end

endmodule

### hw/rtl/midi_running_status_parser_core.sv
// MIDI byte parser with running status.
//
// Input channel: one received MIDI byte per request on i_in_byte, taken at a
// rising edge where i_in_valid is high and o_in_stall is low. Output channel:
// one decoded event per request, taken where o_out_valid is high and
// i_out_stall is low. A byte may cause zero, one or many events; the final
// event caused by a byte carries o_last_of_run.
// Throughput is one byte per cycle while o_in_stall is low. An ordinary
// event passes through the command queue and then the output register
// before it is presented on the output. A sysex end byte replays the store
// one byte per cycle from the sysex memory read port while the receiver
// does not stall, so a block of N stored bytes yields N+1 events; sysex
// bytes that arrive meanwhile are held off by o_in_stall until the replay finishes.
// The front end parses and feeds a two-entry command queue; the back end
// owns the output register, so each side stalls on its own. When the
// receiver stalls, the output holds and the queue fills, then o_in_stall
// rises. Reset empties the queue and output, sets enable, and returns the
// parser to normal mode with no running status. i_cfg_we writes enable.
module midi_running_status_parser_core #(
    parameter int unsigned SYSEX_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_in_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mrsp_pkg::KIND_W-1:0]  o_event_kind,
    output logic [mrsp_pkg::CHAN_W-1:0]  o_channel,
    output logic [mrsp_pkg::KEY_W-1:0]   o_key_or_number,
    output logic [mrsp_pkg::VALUE_W-1:0] o_event_value,
    output logic [mrsp_pkg::LEN_W-1:0]   o_sysex_length,
    output logic                         o_last_of_run
);
    import mrsp_pkg::*;

    localparam int unsigned AW = $clog2(SYSEX_DEPTH);
    localparam int unsigned QW = EVT_W + 1 + AW;

    logic          q_push, q_full, q_valid, q_pop;
    t_evt          push_evt, head_evt, out_evt;
    logic          push_is_end, head_is_end;
    logic [AW-1:0] push_len, head_len, out_len;
    logic [QW-1:0] q_in, q_out;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_data;
    logic          sx_done;

    mrsp_front #(
        .SYSEX_DEPTH (SYSEX_DEPTH),
        .AW          (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_evt     (push_evt),
        .o_q_is_end  (push_is_end),
        .o_q_len     (push_len),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_data  (mem_data),
        .i_sx_done   (sx_done)
    );

    assign q_in = {push_evt, push_is_end, push_len};

    mrsp_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign head_evt    = t_evt'(q_out[QW-1 -: EVT_W]);
    assign head_is_end = q_out[AW];
    assign head_len    = q_out[AW-1:0];

    mrsp_back #(
        .SYSEX_DEPTH (SYSEX_DEPTH),
        .AW          (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_evt     (head_evt),
        .i_q_is_end  (head_is_end),
        .i_q_len     (head_len),
        .o_q_pop     (q_pop),
        .i_mem_we    (mem_we),
        .i_mem_addr  (mem_addr),
        .i_mem_data  (mem_data),
        .o_sx_done   (sx_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_evt       (out_evt),
        .o_len       (out_len),
        .o_last      (o_last_of_run)
    );

    assign o_event_kind    = out_evt.kind;
    assign o_channel       = out_evt.chan;
    assign o_key_or_number = out_evt.key;
    assign o_event_value   = out_evt.value;
    // The reported length is the low bits of the replay count.
    assign o_sysex_length  = LEN_W'(out_len);

endmodule

### dv/midi_running_status_parser_core_tb.sv
`timescale 1ns / 100ps

module midi_running_status_parser_core_tb;
    import mrsp_pkg::*;

    // The default store depth of the block. A sysex block of more than
    // SYSEX_DEPTH-2 data bytes is dropped on its end byte.
    localparam int unsigned SYSEX_DEPTH = 64;
    localparam int          CYCLE_LIMIT = 500000;
    // Cycles that a byte which causes no event may still spend in the block.
    localparam int          SETTLE_CYCLES = 8;

    // One decoded event as it appears on the output ports.
    typedef struct packed {
        t_kind              kind;
        logic [CHAN_W-1:0]  chan;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_midi_event;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {
        ROW_PRED  = 2'd0,
        ROW_QUIET = 2'd1,
        ROW_TYPED = 2'd2
    } t_row_how;

    typedef struct packed {
        t_row_how    how;
        logic [7:0]  rx_byte;
        t_midi_event ev;
    } t_stim_row;

    typedef enum int {
        STALL_NONE  = 0,
        STALL_LIGHT = 1,
        STALL_HEAVY = 2,
        STALL_BEAT  = 3
    } t_stall_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_in_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KIND_W-1:0]    o_event_kind;
    logic [CHAN_W-1:0]    o_channel;
    logic [KEY_W-1:0]     o_key_or_number;
    logic [VALUE_W-1:0]   o_event_value;
    logic [LEN_W-1:0]     o_sysex_length;
    logic                 o_last_of_run;

    midi_running_status_parser_core #(
        .SYSEX_DEPTH(SYSEX_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_channel       (o_channel),
        .o_key_or_number (o_key_or_number),
        .o_event_value   (o_event_value),
        .o_sysex_length  (o_sysex_length),
        .o_last_of_run   (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser model. It keeps its own copy of the enable register and of
    // the parse state, and turns each accepted byte into the events that
    // the block has to produce for it, in order.
    // ------------------------------------------------------------------
    logic             model_enable = 1'b1;
    t_mode            model_mode = MODE_NORMAL;
    logic [7:0]       model_status = 8'h00;
    logic [KEY_W-1:0] model_first = '0;
    logic [7:0]       sysex_bytes [0:SYSEX_DEPTH-1];
    int               sysex_fill = 0;

    // Events caused by the byte just accepted, and all events still owed.
    t_midi_event step_events [$];
    t_midi_event pending_events [$];

    int errors = 0;
    int events_checked = 0;
    int bytes_sent = 0;
    int bytes_acted = 0;
    int sysex_blocks = 0;
    int sysex_dropped = 0;
    int cycles = 0;

    function automatic void queue_event(input t_kind k, input logic [CHAN_W-1:0] ch,
                                        input logic [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] val,
                                        input logic [LEN_W-1:0] len);
        t_midi_event e;
        e.kind  = k;
        e.chan  = ch;
        e.key   = key;
        e.value = val;
        e.len   = len;
        e.last  = 1'b0;
        step_events.push_back(e);
    endfunction

    // Returns 1 when the byte changed the parse state or caused an event,
    // and 0 when the block simply ignores it.
    function automatic bit decode_rx_byte(input logic [7:0] b);
        logic [3:0]        hi;
        logic [CHAN_W-1:0] ch;
        bit                acted;
        hi    = model_status[7:4];
        ch    = model_status[3:0];
        acted = 1'b1;
        step_events.delete();
        if (!model_enable) begin
            return 1'b0;
        end
        case (model_mode)
            MODE_PARAM: begin
                // Whatever arrives here is the second data byte, status or not.
                if (hi == HI_NOTE_OFF) begin
                    queue_event(EV_NOTE_OFF, ch, model_first, '0, '0);
                end else if (hi == HI_NOTE_ON) begin
                    if (b == 8'h00) begin
                        queue_event(EV_NOTE_OFF, ch, model_first, '0, '0);
                    end else begin
                        queue_event(EV_NOTE_ON, ch, model_first, {7'd0, b}, '0);
                    end
                end else if (hi == HI_KEY_PRESS) begin
                    queue_event(EV_KEY_PRESS, ch, model_first, {7'd0, b}, '0);
                end else if (hi == HI_CTRL) begin
                    queue_event(EV_CTRL, ch, model_first, {7'd0, b}, '0);
                end else if (hi == HI_BEND) begin
                    queue_event(EV_BEND, ch, model_first, {b, model_first}, '0);
                end
                model_mode = MODE_NORMAL;
            end
            MODE_SYSEX: begin
                if (b == BYTE_SYSEX_END) begin
                    sysex_blocks++;
                    if (sysex_fill < SYSEX_DEPTH - 1) begin
                        for (int i = 0; i < sysex_fill; i++) begin
                            queue_event(EV_SYSEX_BYTE, '0, '0, {7'd0, sysex_bytes[i]}, '0);
                        end
                        queue_event(EV_SYSEX_END, '0, '0, '0, sysex_fill[LEN_W-1:0]);
                    end else begin
                        sysex_dropped++;
                    end
                    model_mode = MODE_NORMAL;
                end else begin
                    if (sysex_fill < SYSEX_DEPTH) begin
                        sysex_bytes[sysex_fill] = b;
                    end
                    if (sysex_fill < SYSEX_DEPTH - 1) begin
                        sysex_fill++;
                    end
                end
            end
            default: begin
                if (!b[7]) begin
                    if (hi == HI_PROGRAM) begin
                        queue_event(EV_PROGRAM, ch, '0, {8'd0, b[6:0]}, '0);
                    end else if (hi == HI_CHAN_PRES) begin
                        queue_event(EV_CHAN_PRES, ch, '0, {8'd0, b[6:0]}, '0);
                    end else if (model_status[7]) begin
                        model_first = b[6:0];
                        model_mode  = MODE_PARAM;
                    end else begin
                        // A data byte with no running status in force.
                        acted = 1'b0;
                    end
                end else if (b < BYTE_SYSEX_START) begin
                    model_status = b;
                end else if (b == BYTE_SYSEX_START) begin
                    sysex_fill = 0;
                    model_mode = MODE_SYSEX;
                end else if (b == BYTE_SYS_RESET) begin
                    queue_event(EV_RESET, '0, '0, '0, '0);
                    model_status = 8'h00;
                end else begin
                    acted = 1'b0;
                end
            end
        endcase
        if (step_events.size() > 0) begin
            step_events[step_events.size() - 1].last = 1'b1;
        end
        return acted;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Bytes go out in bursts of random length; between bursts
    // the valid line drops for a random gap, and some bursts follow each
    // other with no gap at all. When keep is set, the model's events for
    // the byte are added to the owed events at the edge where the request
    // is taken; otherwise the caller decides what is owed.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_byte(input logic [7:0] b, input bit keep);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        if (decode_rx_byte(b)) begin
            bytes_acted++;
        end
        if (keep) begin
            foreach (step_events[i]) begin
                pending_events.push_back(step_events[i]);
            end
        end
    endtask

    // Drops valid, waits until every owed event has come out, and then
    // lets the block finish any byte that caused no event.
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic write_enable(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_enable = v;
    endtask

    // ------------------------------------------------------------------
    // Random message generators.
    // ------------------------------------------------------------------

    // A second data byte: mostly in range, sometimes zero (note on turns
    // into note off), sometimes a status value that still counts as data.
    function automatic logic [7:0] pick_second_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(0, 127));
    endfunction

    // A channel message with a fresh status, followed by more messages
    // that rely on running status. Without a status the run continues
    // whatever status is in force, or none at all.
    task automatic send_channel_run(input bit with_status);
        logic [3:0] hi;
        int         msgs;
        if (with_status) begin
            hi = 4'($urandom_range(8, 14));
            send_byte({hi, 4'($urandom_range(0, 15))}, 1'b1);
        end else begin
            hi = model_status[7:4];
        end
        msgs = $urandom_range(1, 4);
        repeat (msgs) begin
            send_byte(8'($urandom_range(0, 127)), 1'b1);
            if (hi != HI_PROGRAM && hi != HI_CHAN_PRES) begin
                send_byte(pick_second_data(), 1'b1);
            end
        end
    endtask

    // A sysex block. Most are short; a few run past the store so that
    // both the longest replay and the dropped block are reached.
    task automatic send_sysex();
        int         len;
        logic [7:0] b;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(SYSEX_DEPTH - 4, SYSEX_DEPTH + 4)
                                          : $urandom_range(0, 10);
        send_byte(BYTE_SYSEX_START, 1'b1);
        repeat (len) begin
            if ($urandom_range(0, 7) == 0) begin
                b = 8'($urandom_range(128, 255));
                if (b == BYTE_SYSEX_END) begin
                    b = BYTE_SYS_RESET;
                end
            end else begin
                b = 8'($urandom_range(0, 127));
            end
            send_byte(b, 1'b1);
        end
        send_byte(BYTE_SYSEX_END, 1'b1);
    endtask

    // Sends random sequences until the given number of bytes has had an
    // effect on the parser. Most are well formed; the rest is raw noise
    // that also breaks messages off in the middle.
    task automatic send_random_traffic(input int goal);
        int start;
        int r;
        start = bytes_acted;
        while (bytes_acted - start < goal) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_channel_run(1'b1);
            end else if (r < 60) begin
                send_channel_run(1'b0);
            end else if (r < 75) begin
                send_sysex();
            end else if (r < 80) begin
                send_byte(BYTE_SYS_RESET, 1'b1);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver. The stall line follows a style that is picked anew at random:
    // never stalled, lightly stalled, mostly stalled, or a steady beat that
    // is open for longer than it is stalled.
    // ------------------------------------------------------------------
    t_stall_style stall_style = STALL_NONE;
    int           stall_left = 0;
    int           stall_phase = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            stall_left  = $urandom_range(16, 64);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((stall_phase % 8) >= 5);
        endcase
    end

    // ------------------------------------------------------------------
    // Event checker. Every event taken from the block is compared field
    // by field with the oldest owed event.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_events
        t_midi_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $error("event with nothing owed: event_kind %0d, channel %0d, value %0d",
                       o_event_kind, o_channel, o_event_value);
                errors++;
            end else begin
                want = pending_events.pop_front();
                events_checked++;
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, actual %0d", want.kind, o_event_kind);
                    errors++;
                end
                if (o_channel !== want.chan) begin
                    $error("channel: expected %0d, actual %0d", want.chan, o_channel);
                    errors++;
                end
                if (o_key_or_number !== want.key) begin
                    $error("key_or_number: expected %0d, actual %0d", want.key,
                           o_key_or_number);
                    errors++;
                end
                if (o_event_value !== want.value) begin
                    $error("event_value: expected %0d, actual %0d", want.value,
                           o_event_value);
                    errors++;
                end
                if (o_sysex_length !== want.len) begin
                    $error("sysex_length: expected %0d, actual %0d", want.len,
                           o_sysex_length);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Rows whose events are obvious carry them typed in;
    // the others are checked through the model. The model still sees
    // every row, so its state stays in step with the block.
    // ------------------------------------------------------------------
    localparam int DIR_ROWS = 30;

    t_stim_row dir_rows [0:DIR_ROWS-1] = '{
        // A data byte straight after reset has no status to run with.
        '{ROW_QUIET, 8'h40, '0},
        '{ROW_TYPED, BYTE_SYS_RESET, '{EV_RESET, 4'd0, 7'd0, 15'd0, 6'd0, 1'b1}},
        '{ROW_QUIET, {HI_PROGRAM, 4'h5}, '0},
        '{ROW_TYPED, 8'h7F, '{EV_PROGRAM, 4'd5, 7'd0, 15'd127, 6'd0, 1'b1}},
        '{ROW_QUIET, {HI_CHAN_PRES, 4'hF}, '0},
        '{ROW_TYPED, 8'h00, '{EV_CHAN_PRES, 4'd15, 7'd0, 15'd0, 6'd0, 1'b1}},
        // Note on with zero velocity, then a status value as the velocity.
        '{ROW_PRED, {HI_NOTE_ON, 4'h0}, '0},
        '{ROW_PRED, 8'h3C, '0},
        '{ROW_PRED, 8'h00, '0},
        '{ROW_PRED, 8'h3C, '0},
        '{ROW_PRED, 8'hFF, '0},
        '{ROW_PRED, {HI_NOTE_OFF, 4'h9}, '0},
        '{ROW_PRED, 8'h7F, '0},
        '{ROW_PRED, 8'h40, '0},
        '{ROW_PRED, {HI_KEY_PRESS, 4'hE}, '0},
        '{ROW_PRED, 8'h00, '0},
        '{ROW_PRED, 8'h80, '0},
        '{ROW_PRED, {HI_CTRL, 4'h3}, '0},
        '{ROW_PRED, 8'h07, '0},
        '{ROW_PRED, 8'h64, '0},
        // The largest bend value: every bit of both data bytes set.
        '{ROW_PRED, {HI_BEND, 4'hF}, '0},
        '{ROW_PRED, 8'h7F, '0},
        '{ROW_TYPED, 8'hFF, '{EV_BEND, 4'd15, 7'd127, 15'h7FFF, 6'd0, 1'b1}},
        // Another system byte in normal mode is ignored.
        '{ROW_QUIET, 8'hF1, '0},
        // Empty sysex block.
        '{ROW_QUIET, BYTE_SYSEX_START, '0},
        '{ROW_TYPED, BYTE_SYSEX_END, '{EV_SYSEX_END, 4'd0, 7'd0, 15'd0, 6'd0, 1'b1}},
        // Short sysex block that stores a status byte too.
        '{ROW_PRED, BYTE_SYSEX_START, '0},
        '{ROW_PRED, 8'h55, '0},
        '{ROW_PRED, 8'hFE, '0},
        '{ROW_PRED, BYTE_SYSEX_END, '0}
    };

    initial begin : stimulus
        logic [7:0] held_first;
        // Synchronous reset at the start, never raised again.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_enable(1'b1);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_rows[i].rx_byte, dir_rows[i].how == ROW_PRED);
            if (dir_rows[i].how == ROW_TYPED) begin
                pending_events.push_back(dir_rows[i].ev);
            end
        end

        send_random_traffic(90);

        // Leave the parser between the two data bytes of a controller
        // message, switch it off and feed it noise. Once it is switched
        // back on, the held message must complete as if nothing came.
        send_byte({HI_CTRL, 4'($urandom_range(0, 15))}, 1'b1);
        held_first = 8'($urandom_range(0, 127));
        send_byte(held_first, 1'b1);
        settle();
        write_enable(1'b0);
        repeat (20) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        settle();
        write_enable(1'b1);
        send_byte(pick_second_data(), 1'b1);

        send_random_traffic(90);
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes, %0d of them acted on; checked %0d events.",
                 bytes_sent, bytes_acted, events_checked);
        $display("Sysex blocks: %0d, dropped on overflow: %0d; enable toggled off and on.",
                 sysex_blocks, sysex_dropped);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
